// ===== src/mfcw_pkg.sv =====
// Shared constants and codes for the clipped-window 2-D median filter.
package mfcw_pkg;

  // Default build sizes
  localparam int MaxRadius = 2;
  localparam int MaxWidth  = 2048;
  localparam int PixelBits = 16;

  // Frame height limit and register widths
  localparam int HeightLimit = 4096;
  localparam int RowW        = 12;
  localparam int HeightW     = 13;
  localparam int RadiusW     = 2;
  localparam int WidthRegW   = 12;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 13;

  // Reset values of the configuration registers
  localparam logic [RadiusW-1:0]   RadiusReset = 2'd1;
  localparam logic [WidthRegW-1:0] WidthReset  = 12'd2048;
  localparam logic [HeightW-1:0]   HeightReset = 13'd1024;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgRadius = 2'd0,
    CfgWidth  = 2'd1,
    CfgHeight = 2'd2
  } cfg_reg_e;

  // Kind of input item
  typedef enum logic {
    ReqPixel = 1'b0,
    ReqFlush = 1'b1
  } req_type_e;

endpackage

// ===== src/median_filter_2d_clipped_window_unit.sv =====
// Streaming 2-D median filter over a clipped square window.
//
// Input channel (in_valid_i / in_stall_o): one item per accepted cycle, either a
// raster pixel or a flush tick. Output channel (out_valid_o / out_stall_i): one
// filtered pixel per result item in raster order, frame_last_o marking the
// frame's final pixel. An item is taken when valid is high and stall is low.
// Throughput is one item per clock while in_stall_o is low. A result caused by
// an item leaves the output register after passing, in order, the line store
// read, window assembly, pairwise compare, rank count and median select stages.
// Stages are elastic: bubbles close up while the receiver stalls, and in_stall_o
// rises only when every stage holds an item and the output is stalled.
// The line store is (2*MAX_RADIUS+1) copies of (3*MAX_RADIUS+1) row banks of
// 2**$clog2(MAX_WIDTH) pixels each, so each window column has its own read port.
// Reset loads radius 1, width 2048, height 1024 and restarts the frame; the line
// store is not cleared, as no entry is read before the frame has written it.
// A write to index 0, 1 or 2 restarts the frame; write only while the block is idle.
module median_filter_2d_clipped_window_unit #(
  parameter int MAX_RADIUS = mfcw_pkg::MaxRadius,
  parameter int MAX_WIDTH  = mfcw_pkg::MaxWidth,
  parameter int PIXEL_BITS = mfcw_pkg::PixelBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mfcw_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mfcw_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic [PIXEL_BITS-1:0]         pixel_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [PIXEL_BITS-1:0]         pixel_out_o,
  output logic                          frame_last_o
);

  localparam int Dim      = 2 * MAX_RADIUS + 1;
  localparam int Win      = Dim * Dim;
  localparam int Slots    = 3 * MAX_RADIUS + 1;
  localparam int SlotW    = $clog2(Slots);
  localparam int SumW     = $clog2(3 * Slots);
  localparam int ColW     = $clog2(MAX_WIDTH);
  localparam int MemDepth = 1 << ColW;
  localparam int WEffW    = $clog2(MAX_WIDTH + 1);
  localparam int CmpW     = ColW + 2;
  localparam int RowW     = mfcw_pkg::RowW;
  localparam int HW       = mfcw_pkg::HeightW;
  localparam int RW       = mfcw_pkg::RadiusW;
  localparam int DW       = $clog2(MAX_WIDTH * mfcw_pkg::HeightLimit + 1);
  localparam int CntW     = $clog2(Win + 1);

  // Reduce base + offset into the slot range
  function automatic logic [SlotW-1:0] slot_of(input logic [SlotW-1:0] base, input int off);
    logic [SumW-1:0] v;
    v = SumW'(base) + SumW'(Slots + off - MAX_RADIUS);
    if (v >= SumW'(Slots)) v = v - SumW'(Slots);
    if (v >= SumW'(Slots)) v = v - SumW'(Slots);
    return SlotW'(v);
  endfunction

  // Configuration registers
  logic [RW-1:0]                  radius_q;
  logic [mfcw_pkg::WidthRegW-1:0] fwidth_q;
  logic [HW-1:0]                  fheight_q;
  logic                           cfg_hit;

  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        mfcw_pkg::CfgRadius: cfg_hit = 1'b1;
        mfcw_pkg::CfgWidth:  cfg_hit = 1'b1;
        mfcw_pkg::CfgHeight: cfg_hit = 1'b1;
        default:             cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q  <= mfcw_pkg::RadiusReset;
      fwidth_q  <= mfcw_pkg::WidthReset;
      fheight_q <= mfcw_pkg::HeightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mfcw_pkg::CfgRadius: radius_q  <= cfg_data_i[RW-1:0];
        mfcw_pkg::CfgWidth:  fwidth_q  <= cfg_data_i[mfcw_pkg::WidthRegW-1:0];
        mfcw_pkg::CfgHeight: fheight_q <= cfg_data_i[HW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the registers into the supported range
  logic [RW-1:0]    r_eff;
  logic [WEffW-1:0] w_eff;
  logic [HW-1:0]    h_eff;
  logic [DW-1:0]    thr;

  always_comb begin
    r_eff = (32'(radius_q) > MAX_RADIUS) ? RW'(MAX_RADIUS) : radius_q;
    if (fwidth_q == '0) begin
      w_eff = WEffW'(1);
    end else if (32'(fwidth_q) > MAX_WIDTH) begin
      w_eff = WEffW'(MAX_WIDTH);
    end else begin
      w_eff = WEffW'(fwidth_q);
    end
    if (fheight_q == '0) begin
      h_eff = HW'(1);
    end else if (32'(fheight_q) > mfcw_pkg::HeightLimit) begin
      h_eff = HW'(mfcw_pkg::HeightLimit);
    end else begin
      h_eff = fheight_q;
    end
    thr = DW'(r_eff) * DW'(w_eff) + DW'(r_eff);
  end

  // Frame position state
  logic [ColW-1:0]  in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RowW-1:0]  in_row_q, in_row_d, out_row_q, out_row_d;
  logic [SlotW-1:0] in_slot_q, in_slot_d, out_slot_q, out_slot_d;
  logic             in_full_q, in_full_d;
  logic [DW-1:0]    lag_q, lag_d, lag_add;

  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic accept, take, emit, full_nx;
  logic in_col_end, in_row_end, out_col_end, out_last;

  assign accept      = in_valid_i && !in_stall_o;
  assign take        = accept && (req_type_i == mfcw_pkg::ReqPixel) && !in_full_q;
  assign in_col_end  = WEffW'(in_col_q) == (w_eff - 1'b1);
  assign in_row_end  = HW'(in_row_q) == (h_eff - 1'b1);
  assign out_col_end = WEffW'(out_col_q) == (w_eff - 1'b1);
  assign out_last    = out_col_end && (HW'(out_row_q) == (h_eff - 1'b1));
  assign full_nx     = in_full_q || (take && in_col_end && in_row_end);
  assign lag_add     = lag_q + DW'(take);
  assign emit        = accept && (full_nx || (lag_add > thr));

  // Advance input and output positions
  always_comb begin
    in_col_d   = in_col_q;
    in_row_d   = in_row_q;
    in_slot_d  = in_slot_q;
    in_full_d  = full_nx;
    out_col_d  = out_col_q;
    out_row_d  = out_row_q;
    out_slot_d = out_slot_q;
    lag_d      = lag_add;
    if (take) begin
      if (in_col_end) begin
        in_col_d = '0;
        if (in_row_end) begin
          in_row_d  = '0;
          in_slot_d = '0;
        end else begin
          in_row_d  = in_row_q + 1'b1;
          in_slot_d = (in_slot_q == SlotW'(Slots - 1)) ? '0 : in_slot_q + 1'b1;
        end
      end else begin
        in_col_d = in_col_q + 1'b1;
      end
    end
    if (emit) begin
      if (out_last) begin
        in_col_d   = '0;
        in_row_d   = '0;
        in_slot_d  = '0;
        in_full_d  = 1'b0;
        out_col_d  = '0;
        out_row_d  = '0;
        out_slot_d = '0;
        lag_d      = '0;
      end else begin
        lag_d = lag_add - 1'b1;
        if (out_col_end) begin
          out_col_d  = '0;
          out_row_d  = out_row_q + 1'b1;
          out_slot_d = (out_slot_q == SlotW'(Slots - 1)) ? '0 : out_slot_q + 1'b1;
        end else begin
          out_col_d = out_col_q + 1'b1;
        end
      end
    end
    if (cfg_hit) begin
      in_col_d   = '0;
      in_row_d   = '0;
      in_slot_d  = '0;
      in_full_d  = 1'b0;
      out_col_d  = '0;
      out_row_d  = '0;
      out_slot_d = '0;
      lag_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_slot_q  <= '0;
      in_full_q  <= 1'b0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_slot_q <= '0;
      lag_q      <= '0;
    end else begin
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      in_slot_q  <= in_slot_d;
      in_full_q  <= in_full_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      out_slot_q <= out_slot_d;
      lag_q      <= lag_d;
    end
  end

  // Window addressing: columns, rows, bank slots and in-bounds mask
  logic [ColW:0]    ccol   [Dim];
  logic [ColW-1:0]  rd_col [Dim];
  logic             col_ok [Dim];
  logic [HW:0]      crow   [Dim];
  logic             row_ok [Dim];
  logic [SlotW-1:0] slot_d [Dim];
  logic [Win-1:0]   mask_d;
  logic             byp_d  [Dim][Slots];

  always_comb begin
    for (int d = 0; d < Dim; d++) begin
      ccol[d]   = {1'b0, out_col_q} + (ColW + 1)'(d);
      rd_col[d] = ColW'(ccol[d] - (ColW + 1)'(MAX_RADIUS));
      col_ok[d] = (d >= MAX_RADIUS - 32'(r_eff)) && (d <= MAX_RADIUS + 32'(r_eff))
               && (ccol[d] >= (ColW + 1)'(MAX_RADIUS))
               && ((CmpW'(ccol[d]) - CmpW'(MAX_RADIUS)) < CmpW'(w_eff));
      crow[d]   = (HW + 1)'(out_row_q) + (HW + 1)'(d);
      row_ok[d] = (d >= MAX_RADIUS - 32'(r_eff)) && (d <= MAX_RADIUS + 32'(r_eff))
               && (crow[d] >= (HW + 1)'(MAX_RADIUS))
               && ((crow[d] - (HW + 1)'(MAX_RADIUS)) < (HW + 1)'(h_eff));
      slot_d[d] = slot_of(out_slot_q, d);
      for (int s = 0; s < Slots; s++) begin
        byp_d[d][s] = take && (in_slot_q == SlotW'(s)) && (in_col_q == rd_col[d]);
      end
    end
    for (int y = 0; y < Dim; y++) begin
      for (int x = 0; x < Dim; x++) begin
        mask_d[y * Dim + x] = row_ok[y] && col_ok[x];
      end
    end
  end

  // Elastic stage handshake
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, out_valid_q;

  assign rdy5       = !out_valid_q || !out_stall_i;
  assign rdy4       = !s4_valid_q || rdy5;
  assign rdy3       = !s3_valid_q || rdy4;
  assign rdy2       = !s2_valid_q || rdy3;
  assign rdy1       = !s1_valid_q || rdy2;
  assign in_stall_o = !rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rdy1) s1_valid_q  <= emit;
      if (rdy2) s2_valid_q  <= s1_valid_q;
      if (rdy3) s3_valid_q  <= s2_valid_q;
      if (rdy4) s4_valid_q  <= s3_valid_q;
      if (rdy5) out_valid_q <= s4_valid_q;
    end
  end

  // Line store banks: one copy per window column, one bank per row slot
  logic [PIXEL_BITS-1:0] rdata [Dim][Slots];

  for (genvar gx = 0; gx < Dim; gx++) begin : g_copy
    for (genvar gs = 0; gs < Slots; gs++) begin : g_bank
      logic [PIXEL_BITS-1:0] bank_q [MemDepth];
      logic [PIXEL_BITS-1:0] rd_q;
      always_ff @(posedge clk_i) begin
        if (take && (in_slot_q == SlotW'(gs))) bank_q[in_col_q] <= pixel_in_i;
        if (rdy1) rd_q <= bank_q[rd_col[gx]];
      end
      assign rdata[gx][gs] = rd_q;
    end
  end

  // Stage 1: read data plus write bypass
  logic                  s1_byp_q   [Dim][Slots];
  logic [SlotW-1:0]      s1_slot_q  [Dim];
  logic [PIXEL_BITS-1:0] s1_wdata_q;
  logic [Win-1:0]        s1_mask_q;
  logic                  s1_last_q;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_byp_q   <= byp_d;
      s1_slot_q  <= slot_d;
      s1_wdata_q <= pixel_in_i;
      s1_mask_q  <= mask_d;
      s1_last_q  <= out_last;
    end
  end

  // Stage 2: assemble the window and the median rank
  logic [PIXEL_BITS-1:0] win_d [Win];
  logic [CntW-1:0]       cnt_d;
  logic [PIXEL_BITS-1:0] s2_win_q [Win];
  logic [Win-1:0]        s2_mask_q;
  logic [CntW-1:0]       s2_tgt_q;
  logic                  s2_last_q;

  always_comb begin
    cnt_d = '0;
    for (int y = 0; y < Dim; y++) begin
      for (int x = 0; x < Dim; x++) begin
        win_d[y * Dim + x] = s1_byp_q[x][s1_slot_q[y]] ? s1_wdata_q
                                                        : rdata[x][s1_slot_q[y]];
      end
    end
    for (int i = 0; i < Win; i++) cnt_d = cnt_d + CntW'(s1_mask_q[i]);
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      s2_win_q  <= win_d;
      s2_mask_q <= s1_mask_q;
      s2_tgt_q  <= cnt_d >> 1;
      s2_last_q <= s1_last_q;
    end
  end

  // Stage 3: pairwise order, ties broken by window position
  logic [Win-1:0]        below_d [Win];
  logic [Win-1:0]        s3_below_q [Win];
  logic [PIXEL_BITS-1:0] s3_win_q [Win];
  logic [Win-1:0]        s3_mask_q;
  logic [CntW-1:0]       s3_tgt_q;
  logic                  s3_last_q;

  always_comb begin
    for (int i = 0; i < Win; i++) begin
      for (int j = 0; j < Win; j++) begin
        below_d[i][j] = (i != j) && s2_mask_q[j]
                     && ((s2_win_q[j] < s2_win_q[i])
                     || ((s2_win_q[j] == s2_win_q[i]) && (j < i)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      s3_below_q <= below_d;
      s3_win_q   <= s2_win_q;
      s3_mask_q  <= s2_mask_q;
      s3_tgt_q   <= s2_tgt_q;
      s3_last_q  <= s2_last_q;
    end
  end

  // Stage 4: pick the element whose rank is the target
  logic [Win-1:0]        sel_d;
  logic [CntW-1:0]       rank_d [Win];
  logic [Win-1:0]        s4_sel_q;
  logic [PIXEL_BITS-1:0] s4_win_q [Win];
  logic                  s4_last_q;

  always_comb begin
    for (int i = 0; i < Win; i++) begin
      rank_d[i] = '0;
      for (int j = 0; j < Win; j++) rank_d[i] = rank_d[i] + CntW'(s3_below_q[i][j]);
      sel_d[i] = s3_mask_q[i] && (rank_d[i] == s3_tgt_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      s4_sel_q  <= sel_d;
      s4_win_q  <= s3_win_q;
      s4_last_q <= s3_last_q;
    end
  end

  // Output register: one-hot select of the median
  logic [PIXEL_BITS-1:0] med_d;
  logic [PIXEL_BITS-1:0] out_pixel_q;
  logic                  out_last_q;

  always_comb begin
    med_d = '0;
    for (int i = 0; i < Win; i++) med_d = med_d | (s4_sel_q[i] ? s4_win_q[i] : '0);
  end

  always_ff @(posedge clk_i) begin
    if (rdy5) begin
      out_pixel_q <= med_d;
      out_last_q  <= s4_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_out_o  = out_pixel_q;
  assign frame_last_o = out_last_q;

endmodule

// ===== src/mfcw_checker.sv =====
// Port-level checks for the median filter unit, bound onto the top level.
module mfcw_checker #(
  parameter int PIXEL_BITS = mfcw_pkg::PixelBits
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [PIXEL_BITS-1:0] pixel_out_o,
  input logic                  frame_last_o
);

  // Hold a stalled result item unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_out_o)
                                   && $stable(frame_last_o))
    else $error("stalled result item changed");

  // Stall the input only when the output is full and stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while the output could drain");

  // Drop all items in flight at reset
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o && !in_stall_o)
    else $error("item or stall present after reset");

endmodule

bind median_filter_2d_clipped_window_unit mfcw_checker u_mfcw_checker (.*);
